/* rtl/core/multi_button_press_hold_detector_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the press and hold detector checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_PRESS_HOLD_DETECTOR_DEFINES_SVH
`define MULTI_BUTTON_PRESS_HOLD_DETECTOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define MBPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MBPH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mbph_pkg.sv */
// ----------------------------------------------------------------------------
// mbph_pkg
// Types and codes shared by the press and hold detector modules.
// ----------------------------------------------------------------------------
package mbph_pkg;

    // Field widths of the item and status channels.
    localparam int KIND_W   = 2;
    localparam int TOUCH_W  = 8;
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int BTN_W    = 3;
    localparam int CFG_IDX_W = 2;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HELD_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_THR = 2'd1;

    // Reset values of the thresholds.
    localparam logic [DUR_W-1:0] HELD_THR_RST  = 16'd1000;
    localparam logic [DUR_W-1:0] START_THR_RST = 16'd500;

    // Command to one button lane for the current item.
    typedef struct packed {
        logic tick;
        logic clear;
        logic rd_clr;
    } lane_cmd_t;

    // Status of one button lane.
    typedef struct packed {
        logic pressed_released;
        logic started_held;
        logic latched_held;
        logic held_cur;
        logic held_upd;
    } lane_stat_t;

endpackage

/* rtl/core/multi_button_press_hold_detector.sv */
// A tick or reset item takes effect in the cycle after it is accepted. A read item shows
// its first status item the cycle after acceptance, then one per cycle unless stalled.
// Throughput: one tick or reset item per cycle; a read produces BUTTONS status items,
// limited by the single status buffer, and a new read is taken with the final one.
// Reset: all flags clear, thresholds load 1000 and 500; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multi_button_press_hold_detector
// Per-button lanes track press, hold and release; the top merges the held
// state of all lanes and feeds read snapshots to the status buffer.
// ----------------------------------------------------------------------------
module multi_button_press_hold_detector #(
    parameter int BUTTONS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [mbph_pkg::KIND_W-1:0]    kind,
    input  logic [mbph_pkg::TOUCH_W-1:0]   touched,
    input  logic [mbph_pkg::TIME_W-1:0]    now_ms,
    output logic                           status_valid,
    input  logic                           status_stall,
    output logic [mbph_pkg::BTN_W-1:0]     button,
    output logic                           pressed_released,
    output logic                           started_held,
    output logic                           held,
    output logic [mbph_pkg::DUR_W-1:0]     held_duration_ms,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbph_pkg::DUR_W-1:0]     cfg_data
);

    logic                       lockout_reg, lockout_next;
    logic [mbph_pkg::DUR_W-1:0] held_thr_reg, held_thr_next;
    logic [mbph_pkg::DUR_W-1:0] start_thr_reg, start_thr_next;
    logic                       acc;
    logic                       tick_acc;
    logic                       read_acc;
    logic                       rst_acc;
    logic                       out_free;
    mbph_pkg::lane_cmd_t        cmd;
    logic [BUTTONS-1:0]         touch_vec;
    logic [BUTTONS-1:0]         held_cur;
    logic [BUTTONS-1:0]         held_upd;
    logic [BUTTONS-1:0]         other_held;
    logic [BUTTONS-1:0]         pr_vec;
    logic [BUTTONS-1:0]         sh_vec;
    logic [BUTTONS-1:0]         lh_vec;
    logic [mbph_pkg::DUR_W-1:0] ldur [BUTTONS];
    logic [mbph_pkg::DUR_W-1:0] snap_dur [BUTTONS];
    mbph_pkg::lane_stat_t       stat [BUTTONS];

    // Item handshake: only a read waits, and only for the status buffer.
    assign item_stall = (kind == mbph_pkg::KIND_READ) && !out_free;
    assign acc        = item_valid && !item_stall;
    assign tick_acc   = acc && (kind == mbph_pkg::KIND_TICK);
    assign read_acc   = acc && (kind == mbph_pkg::KIND_READ);
    assign rst_acc    = acc && (kind == mbph_pkg::KIND_RESET);

    assign cmd.tick   = tick_acc && !lockout_reg;
    assign cmd.clear  = rst_acc;
    assign cmd.rd_clr = read_acc;

    // Lockout holds off ticks after a reset command until all buttons are up.
    always_comb
    begin
        lockout_next = lockout_reg;
        if (rst_acc)
        begin
            lockout_next = 1'b1;
        end
        else if (tick_acc && lockout_reg && !(|touch_vec))
        begin
            lockout_next = 1'b0;
        end
    end

    // Configuration writes; indexes past the list are dropped.
    assign cfg_ready = 1'b1;
    always_comb
    begin
        held_thr_next  = held_thr_reg;
        start_thr_next = start_thr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                mbph_pkg::CFG_HELD_THR:  held_thr_next  = cfg_data;
                mbph_pkg::CFG_START_THR: start_thr_next = cfg_data;
                default:                 ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg   <= 1'b0;
            held_thr_reg  <= mbph_pkg::HELD_THR_RST;
            start_thr_reg <= mbph_pkg::START_THR_RST;
        end
        else
        begin
            lockout_reg   <= lockout_next;
            held_thr_reg  <= held_thr_next;
            start_thr_reg <= start_thr_next;
        end
    end

    // Button lanes.
    for (genvar i = 0; i < BUTTONS; i++)
    begin : g_lane
        if (i < mbph_pkg::TOUCH_W)
        begin : g_touch
            assign touch_vec[i] = touched[i];
        end
        else
        begin : g_none
            assign touch_vec[i] = 1'b0;
        end

        // Buttons are updated in index order: lower lanes show their new
        // held flag, higher lanes their flag from before the tick.
        localparam logic [BUTTONS:0] LO_MASK = (BUTTONS+1)'((64'd1 << i) - 64'd1);
        localparam logic [BUTTONS:0] HI_MASK = ~((BUTTONS+1)'((64'd1 << (i + 1)) - 64'd1));
        assign other_held[i] = |(held_upd & LO_MASK[BUTTONS-1:0])
                             | |(held_cur & HI_MASK[BUTTONS-1:0]);

        mbph_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .touch       (touch_vec[i]),
            .now_lo      (now_ms[mbph_pkg::DUR_W-1:0]),
            .held_thr    (held_thr_reg),
            .start_thr   (start_thr_reg),
            .other_held  (other_held[i]),
            .stat        (stat[i]),
            .latched_dur (ldur[i])
        );

        assign held_cur[i] = stat[i].held_cur;
        assign held_upd[i] = stat[i].held_upd;
        assign pr_vec[i]   = stat[i].pressed_released;
        assign sh_vec[i]   = stat[i].started_held;
        assign lh_vec[i]   = stat[i].latched_held;
        assign snap_dur[i] = stat[i].latched_held ? ldur[i] : '0;
    end

    // Status buffer.
    mbph_out #(
        .BUTTONS (BUTTONS)
    ) u_out
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (read_acc),
        .pr_in            (pr_vec),
        .sh_in            (sh_vec),
        .lh_in            (lh_vec),
        .dur_in           (snap_dur),
        .free             (out_free),
        .status_valid     (status_valid),
        .status_stall     (status_stall),
        .button           (button),
        .pressed_released (pressed_released),
        .started_held     (started_held),
        .held             (held),
        .held_duration_ms (held_duration_ms),
        .last             (last)
    );

endmodule

/* rtl/core/mbph_lane.sv */
// ----------------------------------------------------------------------------
// mbph_lane
// State and update logic of one touch button.
// ----------------------------------------------------------------------------
module mbph_lane
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mbph_pkg::lane_cmd_t        cmd,
    input  logic                       touch,
    input  logic [mbph_pkg::DUR_W-1:0] now_lo,
    input  logic [mbph_pkg::DUR_W-1:0] held_thr,
    input  logic [mbph_pkg::DUR_W-1:0] start_thr,
    input  logic                       other_held,
    output mbph_pkg::lane_stat_t       stat,
    output logic [mbph_pkg::DUR_W-1:0] latched_dur
);

    logic                       down_reg, down_next;
    logic                       held_reg, held_next;
    logic                       sh_reg, sh_next;
    logic                       pr_reg, pr_next;
    logic                       lh_reg, lh_next;
    logic [mbph_pkg::DUR_W-1:0] stamp_reg, stamp_next;
    logic [mbph_pkg::DUR_W-1:0] ldur_reg, ldur_next;
    logic [mbph_pkg::DUR_W-1:0] dur;

    // Only the low 16 bits of the stamp matter for a 16-bit wrapped duration.
    assign dur = now_lo - stamp_reg;

    // Next state of the button for the current item.
    always_comb
    begin
        down_next  = down_reg;
        held_next  = held_reg;
        sh_next    = sh_reg;
        pr_next    = pr_reg;
        lh_next    = lh_reg;
        stamp_next = stamp_reg;
        ldur_next  = ldur_reg;
        if (cmd.clear)
        begin
            down_next = 1'b0;
            held_next = 1'b0;
            sh_next   = 1'b0;
            pr_next   = 1'b0;
            lh_next   = 1'b0;
        end
        else if (cmd.rd_clr)
        begin
            lh_next = 1'b0;
        end
        else if (cmd.tick)
        begin
            if (touch)
            begin
                if (down_reg)
                begin
                    if (dur > held_thr)
                    begin
                        held_next = 1'b1;
                    end
                    if (dur > start_thr)
                    begin
                        sh_next = 1'b1;
                    end
                end
                else
                begin
                    down_next  = 1'b1;
                    stamp_next = now_lo;
                end
            end
            else
            begin
                // A release counts only when no button is held at that point.
                if (!other_held && !held_reg && down_reg)
                begin
                    pr_next = 1'b1;
                end
                down_next = 1'b0;
                held_next = 1'b0;
                sh_next   = 1'b0;
            end
            if (held_next)
            begin
                lh_next   = 1'b1;
                ldur_next = dur;
            end
        end
    end

    // Flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg <= 1'b0;
            held_reg <= 1'b0;
            sh_reg   <= 1'b0;
            pr_reg   <= 1'b0;
            lh_reg   <= 1'b0;
        end
        else
        begin
            down_reg <= down_next;
            held_reg <= held_next;
            sh_reg   <= sh_next;
            pr_reg   <= pr_next;
            lh_reg   <= lh_next;
        end
    end

    // Time stamp and latched duration.
    always_ff @(posedge clk)
    begin
        stamp_reg <= stamp_next;
        ldur_reg  <= ldur_next;
    end

    assign stat.pressed_released = pr_reg;
    assign stat.started_held     = sh_reg;
    assign stat.latched_held     = lh_reg;
    assign stat.held_cur         = held_reg;
    assign stat.held_upd         = held_next;
    assign latched_dur           = ldur_reg;

endmodule

/* rtl/core/mbph_out.sv */
// ----------------------------------------------------------------------------
// mbph_out
// Status buffer that takes a snapshot of all buttons and sends one item each.
// ----------------------------------------------------------------------------
module mbph_out #(
    parameter int BUTTONS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [BUTTONS-1:0]         pr_in,
    input  logic [BUTTONS-1:0]         sh_in,
    input  logic [BUTTONS-1:0]         lh_in,
    input  logic [mbph_pkg::DUR_W-1:0] dur_in [BUTTONS],
    output logic                       free,
    output logic                       status_valid,
    input  logic                       status_stall,
    output logic [mbph_pkg::BTN_W-1:0] button,
    output logic                       pressed_released,
    output logic                       started_held,
    output logic                       held,
    output logic [mbph_pkg::DUR_W-1:0] held_duration_ms,
    output logic                       last
);

    localparam int CW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    logic                       busy_reg, busy_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [BUTTONS-1:0]         pr_reg, pr_next;
    logic [BUTTONS-1:0]         sh_reg, sh_next;
    logic [BUTTONS-1:0]         lh_reg, lh_next;
    logic [mbph_pkg::DUR_W-1:0] dur_reg [BUTTONS];
    logic [mbph_pkg::DUR_W-1:0] dur_shift [BUTTONS];
    logic                       take;
    logic                       at_last;

    assign at_last = (cnt_reg == CW'(BUTTONS - 1));
    assign take    = busy_reg && !status_stall;
    assign free    = !busy_reg || (take && at_last);

    // Snapshot shift line: the head entry is the button being sent.
    for (genvar k = 0; k < BUTTONS; k++)
    begin : g_shift
        if (k == BUTTONS - 1)
        begin : g_end
            assign dur_shift[k] = '0;
        end
        else
        begin : g_mid
            assign dur_shift[k] = dur_reg[k+1];
        end
    end

    // Sequencing of the status items.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        pr_next   = pr_reg;
        sh_next   = sh_reg;
        lh_next   = lh_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            pr_next   = pr_in;
            sh_next   = sh_in;
            lh_next   = lh_in;
        end
        else if (take)
        begin
            pr_next = pr_reg >> 1;
            sh_next = sh_reg >> 1;
            lh_next = lh_reg >> 1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Snapshot registers.
    always_ff @(posedge clk)
    begin
        pr_reg <= pr_next;
        sh_reg <= sh_next;
        lh_reg <= lh_next;
        for (int k = 0; k < BUTTONS; k++)
        begin
            if (load)
            begin
                dur_reg[k] <= dur_in[k];
            end
            else if (take)
            begin
                dur_reg[k] <= dur_shift[k];
            end
        end
    end

    assign status_valid     = busy_reg;
    assign button           = mbph_pkg::BTN_W'(cnt_reg);
    assign pressed_released = pr_reg[0];
    assign started_held     = sh_reg[0];
    assign held             = lh_reg[0];
    assign held_duration_ms = dur_reg[0];
    assign last             = at_last;

endmodule

/* rtl/core/mbph_checker.sv */
// ----------------------------------------------------------------------------
// mbph_checker
// Port-level checks of the status sequence of the press and hold detector.
// ----------------------------------------------------------------------------
`include "multi_button_press_hold_detector_defines.svh"

module mbph_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_stall,
    input  logic [mbph_pkg::KIND_W-1:0]  kind,
    input  logic                         status_valid,
    input  logic                         status_stall,
    input  logic [mbph_pkg::BTN_W-1:0]   button,
    input  logic [mbph_pkg::DUR_W-1:0]   held_duration_ms,
    input  logic                         held,
    input  logic                         last
);

    logic st_take;
    logic rd_take;

    assign st_take = status_valid && !status_stall;
    assign rd_take = item_valid && !item_stall && (kind == mbph_pkg::KIND_READ);

    // A stalled status item keeps its button index.
    `MBPH_ASSERT_NEXT(a_stall_hold, clk, rst_n, status_valid && status_stall, status_valid && $stable(button), "stalled status item changed")

    // Status items of one read follow each other in button order.
    `MBPH_ASSERT_NEXT(a_next_button, clk, rst_n, st_take && !last, status_valid && (button == $past(button) + 3'd1), "status items out of order")

    // A read on an empty buffer starts at button zero.
    `MBPH_ASSERT_NEXT(a_first_button, clk, rst_n, rd_take && (!status_valid || (st_take && last)), status_valid && (button == '0), "read did not start at button zero")

    // A button that is not held reports zero duration.
    `MBPH_ASSERT_SAME(a_dur_zero, clk, rst_n, status_valid && !held, held_duration_ms == '0, "duration without held flag")

endmodule

bind multi_button_press_hold_detector mbph_checker u_mbph_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .kind             (kind),
    .status_valid     (status_valid),
    .status_stall     (status_stall),
    .button           (button),
    .held_duration_ms (held_duration_ms),
    .held             (held),
    .last             (last)
);

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Checks the multi-button press and hold detector against a cycle-free
// model of its tick, read and reset behavior. Touch ticks, status reads and
// reset commands are sent with random gaps. The status channel is stalled
// in random bursts. Every status item is compared field by field with the
// predicted read snapshot, over several threshold settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_BTN      = 8;
    localparam int CYCLE_CAP  = 250000;
    localparam int DRAIN_WAIT = 16;

    // Kind code that the block must ignore.
    localparam logic [mbph_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One status item as it leaves the block.
    typedef struct packed {
        logic [mbph_pkg::BTN_W-1:0] button;
        logic                       pressed_released;
        logic                       started_held;
        logic                       held;
        logic [mbph_pkg::DUR_W-1:0] held_duration_ms;
        logic                       last;
    } status_t;

    // Tracks the button state the block should hold and the status items
    // each read must produce.
    class press_hold_scoreboard;
        logic [mbph_pkg::DUR_W-1:0]  held_thr;
        logic [mbph_pkg::DUR_W-1:0]  start_thr;
        bit                          locked;
        bit                          down      [N_BTN];
        bit                          held_now  [N_BTN];
        bit                          start_now [N_BTN];
        bit                          tapped    [N_BTN];
        bit                          held_seen [N_BTN];
        logic [mbph_pkg::TIME_W-1:0] stamp     [N_BTN];
        logic [mbph_pkg::DUR_W-1:0]  dur       [N_BTN];
        logic [mbph_pkg::DUR_W-1:0]  held_dur  [N_BTN];
        status_t                     pending_status[$];
        int                          errors;
        int                          checked;

        function new();
            held_thr  = mbph_pkg::HELD_THR_RST;
            start_thr = mbph_pkg::START_THR_RST;
            locked    = 1'b0;
            errors    = 0;
            checked   = 0;
            clear_flags();
            for (int i = 0; i < N_BTN; i++)
            begin
                stamp[i]    = '0;
                held_dur[i] = '0;
            end
        endfunction

        // Flags and durations drop; stamps and latched durations stay.
        function void clear_flags();
            for (int i = 0; i < N_BTN; i++)
            begin
                down[i]      = 1'b0;
                held_now[i]  = 1'b0;
                start_now[i] = 1'b0;
                tapped[i]    = 1'b0;
                held_seen[i] = 1'b0;
                dur[i]       = '0;
            end
        endfunction

        function void set_threshold(input logic [mbph_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [mbph_pkg::DUR_W-1:0] data);
            if (idx == mbph_pkg::CFG_HELD_THR)
                held_thr = data;
            else if (idx == mbph_pkg::CFG_START_THR)
                start_thr = data;
        endfunction

        // Buttons are updated in index order, so the any-held test of a
        // released button sees this tick's update of the lower ones.
        function void apply_tick(input logic [mbph_pkg::TOUCH_W-1:0] t,
                                 input logic [mbph_pkg::TIME_W-1:0] now);
            bit                          any;
            logic [mbph_pkg::TIME_W-1:0] diff;
            if (locked)
            begin
                if (t == '0)
                    locked = 1'b0;
                return;
            end
            for (int i = 0; i < N_BTN; i++)
            begin
                if (t[i])
                begin
                    if (down[i])
                    begin
                        diff   = now - stamp[i];
                        dur[i] = diff[mbph_pkg::DUR_W-1:0];
                        if (dur[i] > held_thr)
                            held_now[i] = 1'b1;
                        if (dur[i] > start_thr)
                            start_now[i] = 1'b1;
                    end
                    else
                    begin
                        down[i]  = 1'b1;
                        stamp[i] = now;
                    end
                end
                else
                begin
                    any = 1'b0;
                    for (int j = 0; j < N_BTN; j++)
                        any |= held_now[j];
                    if (!any && down[i])
                        tapped[i] = 1'b1;
                    dur[i]       = '0;
                    down[i]      = 1'b0;
                    held_now[i]  = 1'b0;
                    start_now[i] = 1'b0;
                end
                if (held_now[i])
                begin
                    held_seen[i] = 1'b1;
                    held_dur[i]  = dur[i];
                end
            end
        endfunction

        // Called for every item the block accepts.
        function void note_item(input logic [mbph_pkg::KIND_W-1:0] k,
                                input logic [mbph_pkg::TOUCH_W-1:0] t,
                                input logic [mbph_pkg::TIME_W-1:0] now);
            status_t s;
            case (k)
                mbph_pkg::KIND_TICK: apply_tick(t, now);
                mbph_pkg::KIND_RESET:
                begin
                    locked = 1'b1;
                    clear_flags();
                end
                mbph_pkg::KIND_READ:
                begin
                    for (int i = 0; i < N_BTN; i++)
                    begin
                        s.button           = i[mbph_pkg::BTN_W-1:0];
                        s.pressed_released = tapped[i];
                        s.started_held     = start_now[i];
                        s.held             = held_seen[i];
                        s.held_duration_ms = held_seen[i] ? held_dur[i] : '0;
                        s.last             = (i == N_BTN - 1);
                        pending_status.push_back(s);
                        held_seen[i] = 1'b0;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        // Called for every status item the testbench accepts.
        function void check_status(input status_t got);
            status_t want;
            if (pending_status.size() == 0)
            begin
                $error("status item for button %0d with no read waiting", got.button);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            checked++;
            compare_field("button", 32'(want.button), 32'(got.button));
            compare_field("pressed_released", 32'(want.pressed_released),
                          32'(got.pressed_released));
            compare_field("started_held", 32'(want.started_held), 32'(got.started_held));
            compare_field("held", 32'(want.held), 32'(got.held));
            compare_field("held_duration_ms", 32'(want.held_duration_ms),
                          32'(got.held_duration_ms));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction

        function int pending();
            return pending_status.size();
        endfunction
    endclass

    logic                                 clk              = 1'b0;
    logic                                 rst_n            = 1'b0;
    logic                                 item_valid       = 1'b0;
    logic                                 item_stall;
    logic [mbph_pkg::KIND_W-1:0]          kind             = mbph_pkg::KIND_TICK;
    logic [mbph_pkg::TOUCH_W-1:0]         touched          = '0;
    logic [mbph_pkg::TIME_W-1:0]          now_ms           = '0;
    logic                                 status_valid;
    logic                                 status_stall     = 1'b0;
    logic [mbph_pkg::BTN_W-1:0]           button;
    logic                                 pressed_released;
    logic                                 started_held;
    logic                                 held;
    logic [mbph_pkg::DUR_W-1:0]           held_duration_ms;
    logic                                 last;
    logic                                 cfg_valid        = 1'b0;
    logic                                 cfg_ready;
    logic [mbph_pkg::CFG_IDX_W-1:0]       cfg_index        = mbph_pkg::CFG_HELD_THR;
    logic [mbph_pkg::DUR_W-1:0]           cfg_data         = '0;

    press_hold_scoreboard         sb;
    bit                           idle_on    = 1'b1;
    int                           stall_left = 0;
    int                           cycles     = 0;
    int                           n_ticks    = 0;
    int                           n_reads    = 0;
    int                           n_resets   = 0;
    int                           n_ignored  = 0;
    int                           n_settings = 0;
    logic [mbph_pkg::TIME_W-1:0]  clock_ms   = '0;
    logic [mbph_pkg::TOUCH_W-1:0] hand       = '0;

    multi_button_press_hold_detector #(.BUTTONS(N_BTN)) uut (.*);

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Status receiver stalls in random bursts, and never in the last part.
    always @(posedge clk)
    begin
        if (!idle_on)
        begin
            stall_left   <= 0;
            status_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            status_stall <= 1'b1;
        end
        else if ($urandom_range(0, 11) == 0)
        begin
            stall_left   <= $urandom_range(1, 19) - 1;
            status_stall <= 1'b1;
        end
        else
        begin
            status_stall <= 1'b0;
        end
    end

    // Results are checked before the item taken at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n && status_valid && !status_stall)
            sb.check_status(status_t'({button, pressed_released, started_held, held,
                                       held_duration_ms, last}));
        if (rst_n && item_valid && !item_stall)
            sb.note_item(kind, touched, now_ms);
    end

    // Sends one item, sometimes with a random gap in front of it.
    task automatic send_item(input logic [mbph_pkg::KIND_W-1:0] k,
                             input logic [mbph_pkg::TOUCH_W-1:0] t,
                             input logic [mbph_pkg::TIME_W-1:0] n);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= k;
        touched    <= t;
        now_ms     <= n;
        do @(posedge clk); while (item_stall);
        case (k)
            mbph_pkg::KIND_TICK:  n_ticks++;
            mbph_pkg::KIND_READ:  n_reads++;
            mbph_pkg::KIND_RESET: n_resets++;
            default:              n_ignored++;
        endcase
    endtask

    // Holds the sender until every status item has come and the block is quiet.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [mbph_pkg::DUR_W-1:0] held_v,
                                  input logic [mbph_pkg::DUR_W-1:0] start_v);
        cfg_valid <= 1'b1;
        cfg_index <= mbph_pkg::CFG_HELD_THR;
        cfg_data  <= held_v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_threshold(mbph_pkg::CFG_HELD_THR, held_v);
        cfg_index <= mbph_pkg::CFG_START_THR;
        cfg_data  <= start_v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_threshold(mbph_pkg::CFG_START_THR, start_v);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Mostly plausible press and release sequences on a steady clock, with
    // reads, reset commands, unused kinds and time jumps mixed in.
    task automatic run_phase(input logic [mbph_pkg::DUR_W-1:0] held_v,
                             input logic [mbph_pkg::DUR_W-1:0] start_v,
                             input int count, input int step_max);
        int sent;
        int pick;
        int idx;
        wait_idle();
        set_thresholds(held_v, start_v);
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if ($urandom_range(0, 9) == 0)
                    hand = mbph_pkg::TOUCH_W'($urandom);
                else if ($urandom_range(0, 2) == 0)
                begin
                    idx       = $urandom_range(0, N_BTN - 1);
                    hand[idx] = ~hand[idx];
                end
                clock_ms += $urandom_range(0, step_max);
                send_item(mbph_pkg::KIND_TICK, hand, clock_ms);
                sent++;
            end
            else if (pick < 84)
            begin
                send_item(mbph_pkg::KIND_READ, mbph_pkg::TOUCH_W'($urandom), $urandom);
                sent++;
            end
            else if (pick < 87)
            begin
                send_item(mbph_pkg::KIND_RESET, mbph_pkg::TOUCH_W'($urandom), $urandom);
                if ($urandom_range(0, 1) == 0)
                    hand = '0;
                sent++;
            end
            else if (pick < 90)
            begin
                send_item(KIND_UNUSED, mbph_pkg::TOUCH_W'($urandom), $urandom);
            end
            else
            begin
                clock_ms = $urandom;
                send_item(mbph_pkg::KIND_TICK, mbph_pkg::TOUCH_W'($urandom), clock_ms);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [mbph_pkg::DUR_W-1:0] rand_held;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset thresholds of 1000 and 500.
        send_item(mbph_pkg::KIND_READ, '0, '0);
        send_item(mbph_pkg::KIND_TICK, 8'hFF, 32'd0);
        send_item(mbph_pkg::KIND_TICK, 8'hFF, 32'd600);
        send_item(mbph_pkg::KIND_TICK, 8'hFF, 32'd1001);
        send_item(mbph_pkg::KIND_READ, 8'hFF, 32'hFFFF_FFFF);
        // All released while held: no pressed-released flag anywhere.
        send_item(mbph_pkg::KIND_TICK, 8'h00, 32'd1010);
        // A short tap sets the sticky flag.
        send_item(mbph_pkg::KIND_TICK, 8'h01, 32'd2000);
        send_item(mbph_pkg::KIND_TICK, 8'h00, 32'd2001);
        // Button 0 held, button 1 not: a joint release flags only button 1.
        send_item(mbph_pkg::KIND_TICK, 8'h01, 32'd3000);
        send_item(mbph_pkg::KIND_TICK, 8'h03, 32'd4500);
        send_item(mbph_pkg::KIND_TICK, 8'h00, 32'd4501);
        send_item(mbph_pkg::KIND_READ, '0, '0);
        // Time wraps across 32 bits, then the duration wraps across 16 bits.
        send_item(mbph_pkg::KIND_TICK, 8'h80, 32'hFFFF_FFF0);
        send_item(mbph_pkg::KIND_TICK, 8'h80, 32'h0000_0400);
        send_item(mbph_pkg::KIND_TICK, 8'h80, 32'h0001_0005);
        send_item(mbph_pkg::KIND_READ, '0, '0);
        // Reset command while a button is down, then lockout until all are up.
        send_item(mbph_pkg::KIND_RESET, 8'hFF, 32'hFFFF_FFFF);
        send_item(mbph_pkg::KIND_TICK, 8'h80, 32'h0002_0000);
        send_item(mbph_pkg::KIND_READ, '0, '0);
        send_item(mbph_pkg::KIND_TICK, 8'h00, 32'hFFFF_FFFF);
        send_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
        send_item(mbph_pkg::KIND_TICK, 8'h40, 32'h0003_0000);
        send_item(mbph_pkg::KIND_READ, '0, '0);

        // Random part over several threshold settings.
        clock_ms = 32'h0010_0000;
        hand     = '0;
        run_phase(16'hFFFF, 16'hFFFF, 45, 30000);
        run_phase(16'h0000, 16'h0000, 45, 3);
        run_phase(16'd30, 16'd12, 75, 12);
        rand_held = mbph_pkg::DUR_W'($urandom);
        run_phase(rand_held, mbph_pkg::DUR_W'($urandom), 40, int'(rand_held) / 3 + 2);
        // Last part without any idling on either side.
        wait_idle();
        idle_on = 1'b0;
        run_phase(16'd60, 16'd80, 45, 25);
        wait_idle();

        $display("Sent %0d ticks, %0d reads, %0d reset commands, %0d unused kinds",
                 n_ticks, n_reads, n_resets, n_ignored);
        $display("Checked %0d status items under %0d threshold settings",
                 sb.checked, n_settings);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
